@@ hw/rtl/apc_pkg.sv @@
// Shared types and constants of the angle PID channel.
package apc_pkg;

  localparam int ANG_W  = 15;
  localparam int RATE_W = 16;
  localparam int DT_W   = 16;
  localparam int GAIN_W = 16;
  localparam int LIM_W  = 15;
  localparam int INT_W  = 16;
  localparam int TERM_W = 24;
  localparam int DRV_W  = 16;
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic signed [15:0] PI_Q12     = 16'sd12868;
  localparam logic signed [15:0] TWO_PI_Q12 = 16'sd25736;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_DRIVE_LIMIT  = 3'd3,
    REG_WINDUP_LIMIT = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_M1GO,
    ST_M1WAIT,
    ST_INTEG,
    ST_M2GO,
    ST_M2WAIT,
    ST_TERMS,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [LIM_W-1:0]  drive_limit;
    logic [LIM_W-1:0]  windup_limit;
  } cfg_t;

endpackage

@@ hw/rtl/apc_smul.sv @@
// Digit-serial signed-by-unsigned multiplier, least significant digit first.
module apc_smul #(
  parameter int AW = 16,
  parameter int BW = 16,
  parameter int DW = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [AW-1:0] a,
  input  logic [BW-1:0]        b,
  output logic                 busy,
  output logic signed [AW+BW-1:0] prod
);

  localparam int NSTEP = BW / DW;
  localparam int CNT_W = $clog2(NSTEP + 1);

  logic signed [AW-1:0]   a_r;
  logic [BW-1:0]          b_r;
  logic signed [AW-1:0]   hi_r;
  logic [BW-1:0]          lo_r;
  logic [CNT_W-1:0]       cnt_r;
  logic signed [AW+DW:0]  pp;
  logic signed [AW+DW:0]  s;

  assign pp = $signed(a_r) * $signed({1'b0, b_r[DW-1:0]});
  assign s  = $signed({{(DW+1){hi_r[AW-1]}}, hi_r}) + pp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(NSTEP);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      hi_r <= '0;
      lo_r <= '0;
    end else if (cnt_r != '0) begin
      b_r  <= b_r >> DW;
      lo_r <= {s[DW-1:0], lo_r[BW-1:DW]};
      hi_r <= s[AW+DW-1:DW];
    end
  end

  assign busy = (cnt_r != '0);
  assign prod = $signed({hi_r, lo_r});

endmodule

@@ hw/rtl/apc_cfg.sv @@
// APB register file holding the gains and limits.
module apc_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [apc_pkg::CFG_AW-1:0] paddr,
  input  logic [apc_pkg::CFG_DW-1:0] pwdata,
  output logic [apc_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output apc_pkg::cfg_t              cfg
);
  import apc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_PROP_GAIN:    cfg_nxt.prop_gain    = pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN:   cfg_nxt.integ_gain   = pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:   cfg_nxt.deriv_gain   = pwdata[GAIN_W-1:0];
        REG_DRIVE_LIMIT:  cfg_nxt.drive_limit  = pwdata[LIM_W-1:0];
        REG_WINDUP_LIMIT: cfg_nxt.windup_limit = pwdata[LIM_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_PROP_GAIN:    prdata = CFG_DW'(cfg_r.prop_gain);
      REG_INTEG_GAIN:   prdata = CFG_DW'(cfg_r.integ_gain);
      REG_DERIV_GAIN:   prdata = CFG_DW'(cfg_r.deriv_gain);
      REG_DRIVE_LIMIT:  prdata = CFG_DW'(cfg_r.drive_limit);
      REG_WINDUP_LIMIT: prdata = CFG_DW'(cfg_r.windup_limit);
      default:          prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/angle_pid_channel.sv @@
// Top level of the angle PID channel: sequencer, datapath and output register.
// Control item: wraps the error, then runs two passes of 16 / DIGIT_W steps on
// two digit-serial multipliers, updating the integral between them, then sums.
// Clear item: zeroes the integral and goes straight to the sum with zero terms.
// One item in flight: in_stall is high until the result is loaded for output.
// Reset (rst_n low, synchronous) idles the FSM, zeroes config, out_valid and integral.
module angle_pid_channel #(
  parameter int DIGIT_W = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [apc_pkg::CFG_AW-1:0] paddr,
  input  logic [apc_pkg::CFG_DW-1:0] pwdata,
  output logic [apc_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_operation,
  input  logic signed [apc_pkg::ANG_W-1:0]  in_target_angle,
  input  logic signed [apc_pkg::ANG_W-1:0]  in_sensed_angle,
  input  logic signed [apc_pkg::RATE_W-1:0] in_sensed_rate,
  input  logic [apc_pkg::DT_W-1:0]          in_time_step,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [apc_pkg::DRV_W-1:0]  out_drive,
  output logic signed [apc_pkg::TERM_W-1:0] out_prop_term,
  output logic signed [apc_pkg::TERM_W-1:0] out_integ_term,
  output logic signed [apc_pkg::TERM_W-1:0] out_deriv_term
);
  import apc_pkg::*;

  localparam int MUL_AW = 16;
  localparam int MUL_PW = MUL_AW + GAIN_W;

  function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [28:0] v);
    if (v > 29'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -29'sd8388608) begin
      return 24'sh800000;
    end
    return v[TERM_W-1:0];
  endfunction

  cfg_t   cfg;
  state_t state_r;
  state_t state_nxt;

  logic signed [ANG_W-1:0]  tgt_r;
  logic signed [ANG_W-1:0]  sen_r;
  logic signed [RATE_W-1:0] rate_r;
  logic [DT_W-1:0]          dt_r;
  logic signed [ANG_W-1:0]  err_r;
  logic signed [INT_W-1:0]  integ_r;
  logic signed [TERM_W-1:0] p_r;
  logic signed [TERM_W-1:0] i_r;
  logic signed [TERM_W-1:0] d_r;
  logic                     out_valid_r;
  logic signed [DRV_W-1:0]  drive_r;
  logic signed [TERM_W-1:0] prop_out_r;
  logic signed [TERM_W-1:0] integ_out_r;
  logic signed [TERM_W-1:0] deriv_out_r;

  logic                     accept;
  logic                     out_load;
  logic                     mul_start;
  logic                     busy_a;
  logic                     busy_b;
  logic signed [MUL_AW-1:0] a_op_a;
  logic signed [MUL_AW-1:0] a_op_b;
  logic [GAIN_W-1:0]        b_op_a;
  logic [GAIN_W-1:0]        b_op_b;
  logic signed [MUL_PW-1:0] prod_a;
  logic signed [MUL_PW-1:0] prod_b;

  logic signed [15:0]       diff;
  logic signed [15:0]       err_wrap;
  logic signed [32:0]       rnd_a16;
  logic signed [32:0]       rnd_a8;
  logic signed [32:0]       rnd_b8;
  logic signed [32:0]       neg_b;
  logic signed [32:0]       rnd_d4;
  logic signed [17:0]       integ_sum;
  logic signed [17:0]       wl;
  logic signed [INT_W-1:0]  integ_nxt;
  logic signed [25:0]       sum;
  logic signed [25:0]       dl;
  logic signed [DRV_W-1:0]  drive_nxt;

  apc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  apc_smul #(.AW(MUL_AW), .BW(GAIN_W), .DW(DIGIT_W)) u_mul_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (a_op_a),
    .b     (b_op_a),
    .busy  (busy_a),
    .prod  (prod_a)
  );

  apc_smul #(.AW(MUL_AW), .BW(GAIN_W), .DW(DIGIT_W)) u_mul_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (a_op_b),
    .b     (b_op_b),
    .busy  (busy_b),
    .prod  (prod_b)
  );

  // operand select for the two multiply passes
  always_comb begin
    if (state_r == ST_M2GO) begin
      a_op_a = integ_r;
      b_op_a = cfg.integ_gain;
      a_op_b = MUL_AW'(rate_r);
      b_op_b = cfg.deriv_gain;
    end else begin
      a_op_a = MUL_AW'(err_r);
      b_op_a = dt_r;
      a_op_b = MUL_AW'(err_r);
      b_op_b = cfg.prop_gain;
    end
  end

  // wrap the angle error into [-pi, pi]
  always_comb begin
    diff = 16'(tgt_r) - 16'(sen_r);
    if (diff > PI_Q12) begin
      err_wrap = diff - TWO_PI_Q12;
    end else if (diff < -PI_Q12) begin
      err_wrap = diff + TWO_PI_Q12;
    end else begin
      err_wrap = diff;
    end
  end

  // round half up, accumulate and clamp the integral
  always_comb begin
    rnd_a16   = 33'(prod_a) + 33'sd32768;
    rnd_a8    = 33'(prod_a) + 33'sd128;
    rnd_b8    = 33'(prod_b) + 33'sd128;
    neg_b     = 33'sd0 - 33'(prod_b);
    rnd_d4    = neg_b + 33'sd8;
    integ_sum = 18'(integ_r) + 18'($signed(rnd_a16[32:16]));
    wl        = $signed({3'b000, cfg.windup_limit});
    if (integ_sum > wl) begin
      integ_nxt = wl[INT_W-1:0];
    end else if (integ_sum < -wl) begin
      integ_nxt = INT_W'(-wl);
    end else begin
      integ_nxt = integ_sum[INT_W-1:0];
    end
  end

  // sum of terms, clamped to the drive limit
  always_comb begin
    sum = 26'(p_r) + 26'(i_r) + 26'(d_r);
    dl  = $signed({11'b0, cfg.drive_limit});
    if (sum > dl) begin
      drive_nxt = dl[DRV_W-1:0];
    end else if (sum < -dl) begin
      drive_nxt = DRV_W'(-dl);
    end else begin
      drive_nxt = sum[DRV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    mul_start = 1'b0;
    out_load  = 1'b0;
    accept    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (in_valid) begin
          state_nxt = (in_operation == OP_CLEAR) ? ST_SUM : ST_WRAP;
        end
      end
      ST_WRAP: state_nxt = ST_M1GO;
      ST_M1GO: begin
        mul_start = 1'b1;
        state_nxt = ST_M1WAIT;
      end
      ST_M1WAIT: begin
        if (!busy_a && !busy_b) begin
          state_nxt = ST_INTEG;
        end
      end
      ST_INTEG: state_nxt = ST_M2GO;
      ST_M2GO: begin
        mul_start = 1'b1;
        state_nxt = ST_M2WAIT;
      end
      ST_M2WAIT: begin
        if (!busy_a && !busy_b) begin
          state_nxt = ST_TERMS;
        end
      end
      ST_TERMS: state_nxt = ST_SUM;
      ST_SUM: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else if (accept && in_operation == OP_CLEAR) begin
      integ_r <= '0;
    end else if (state_r == ST_INTEG) begin
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        tgt_r  <= in_target_angle;
        sen_r  <= in_sensed_angle;
        rate_r <= in_sensed_rate;
        dt_r   <= in_time_step;
        p_r    <= '0;
        i_r    <= '0;
        d_r    <= '0;
      end
      ST_WRAP:  err_r <= err_wrap[ANG_W-1:0];
      ST_INTEG: p_r   <= sat_term(29'($signed(rnd_b8[32:8])));
      ST_TERMS: begin
        i_r <= sat_term(29'($signed(rnd_a8[32:8])));
        d_r <= sat_term(rnd_d4[32:4]);
      end
      default: begin
        err_r <= err_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      drive_r     <= drive_nxt;
      prop_out_r  <= p_r;
      integ_out_r <= i_r;
      deriv_out_r <= d_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_drive      = drive_r;
  assign out_prop_term  = prop_out_r;
  assign out_integ_term = integ_out_r;
  assign out_deriv_term = deriv_out_r;

endmodule

@@ hw/rtl/apc_checker.sv @@
// Port-level assertions for the angle PID channel and their bind.
module apc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_drive,
  input logic signed [23:0] out_prop_term,
  input logic signed [23:0] out_integ_term,
  input logic signed [23:0] out_deriv_term
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_drive) && $stable(out_prop_term) &&
      $stable(out_integ_term) && $stable(out_deriv_term))
    else $error("result beat changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in flight");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive != 16'sh8000)
    else $error("drive outside symmetric range");

endmodule

bind angle_pid_channel apc_checker u_apc_checker (.*);
